>>> rtl/lbpm_pkg.sv
// Package for the light bar pair matcher: types, constants and register
// codes. Depends on nothing.
`default_nettype none
package lbpm_pkg;

   localparam int MAX_BARS_DEF   = 16;
   localparam int MAX_ARMORS_DEF = 64;
   localparam int QUEUE_DEPTH    = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ANGLE_DIFF   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH_RATIO = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_Y_RATIO      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_X_RATIO      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DIST_RATIO   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DIST_RATIO   = 3'd5;

   localparam logic [10:0] RST_MAX_ANGLE_DIFF   = 11'd112;
   localparam logic [8:0]  RST_MAX_LENGTH_RATIO = 9'd51;
   localparam logic [10:0] RST_MAX_Y_RATIO      = 11'd512;
   localparam logic [10:0] RST_MIN_X_RATIO      = 11'd128;
   localparam logic [11:0] RST_MAX_DIST_RATIO   = 12'd1280;
   localparam logic [11:0] RST_MIN_DIST_RATIO   = 12'd256;

   typedef struct packed {
      logic [10:0] max_angle_diff;
      logic [8:0]  max_length_ratio;
      logic [10:0] max_y_ratio;
      logic [10:0] min_x_ratio;
      logic [11:0] max_dist_ratio;
      logic [11:0] min_dist_ratio;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        cx;
      logic [15:0]        cy;
      logic [15:0]        len;
      logic signed [10:0] ang;
   } bar_type;

   typedef struct packed {
      logic        is_end;
      logic        dropped;
      logic [15:0] armor_x;
      logic [15:0] armor_y;
      logic [3:0]  left_index;
      logic [3:0]  right_index;
   } q_entry_type;

   typedef struct packed {
      logic        push;
      q_entry_type entry;
   } q_push_type;

endpackage
`default_nettype wire

>>> rtl/lbpm_if.sv
// Channel interfaces of the light bar pair matcher: bar input and armor
// result. No dependencies.
`default_nettype none
interface lbpm_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        center_x;
   logic [15:0]        center_y;
   logic [15:0]        bar_length;
   logic signed [10:0] bar_angle;
   logic               last_bar;
   modport source (output valid, center_x, center_y, bar_length, bar_angle, last_bar,
                   input ready);
   modport sink   (input valid, center_x, center_y, bar_length, bar_angle, last_bar,
                   output ready);
endinterface

interface lbpm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] armor_x;
   logic [15:0] armor_y;
   logic [3:0]  left_index;
   logic [3:0]  right_index;
   logic        armor_valid;
   logic        overflow;
   logic        last_armor;
   modport source (output valid, armor_x, armor_y, left_index, right_index, armor_valid,
                   overflow, last_armor, input ready);
   modport sink   (input valid, armor_x, armor_y, left_index, right_index, armor_valid,
                   overflow, last_armor, output ready);
endinterface
`default_nettype wire

>>> rtl/lbpm_pair_test.sv
// Four-stage pipelined geometric test of one bar pair.
// Depends on lbpm_pkg.
`default_nettype none
module lbpm_pair_test
   import lbpm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    start,
   input  wire bar_type bar_a,
   input  wire bar_type bar_b,
   output logic         done,
   output logic         pass,
   output logic [15:0]  mean_x,
   output logic [15:0]  mean_y
);

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [15:0] x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff, x4_ff, y4_ff;

   // Stage 1
   logic [10:0] ad_ff;
   logic [15:0] ld_ff, lmax_ff, dx_ff, dy_ff;
   logic [16:0] s_ff;
   logic signed [11:0] adiff;
   logic [16:0] sum_x, sum_y;

   always_comb begin
      adiff = {bar_a.ang[10], bar_a.ang} - {bar_b.ang[10], bar_b.ang};
      sum_x = {1'b0, bar_a.cx} + {1'b0, bar_b.cx};
      sum_y = {1'b0, bar_a.cy} + {1'b0, bar_b.cy};
   end

   always_ff @(posedge clock) begin
      ad_ff   <= adiff[11] ? 11'(-adiff) : adiff[10:0];
      ld_ff   <= (bar_a.len > bar_b.len) ? bar_a.len - bar_b.len : bar_b.len - bar_a.len;
      lmax_ff <= (bar_a.len > bar_b.len) ? bar_a.len : bar_b.len;
      s_ff    <= {1'b0, bar_a.len} + {1'b0, bar_b.len};
      dx_ff   <= (bar_a.cx > bar_b.cx) ? bar_a.cx - bar_b.cx : bar_b.cx - bar_a.cx;
      dy_ff   <= (bar_a.cy > bar_b.cy) ? bar_a.cy - bar_b.cy : bar_b.cy - bar_a.cy;
      x1_ff   <= sum_x[16:1];
      y1_ff   <= sum_y[16:1];
   end

   // Stage 2: angle compare, products of measured values with thresholds and squared distances.
   logic        ang_ok2_ff;
   logic [15:0] ld2_ff, dx2_ff, dy2_ff;
   logic [24:0] p_len_ff;
   logic [27:0] p_y_ff, p_x_ff;
   logic [31:0] dxsq_ff, dysq_ff;
   logic [28:0] hi_ff, lo_ff;

   always_ff @(posedge clock) begin
      ang_ok2_ff <= ad_ff <= cfg.max_angle_diff;
      ld2_ff     <= ld_ff;
      dx2_ff     <= dx_ff;
      dy2_ff     <= dy_ff;
      p_len_ff   <= 25'(cfg.max_length_ratio) * 25'(lmax_ff);
      p_y_ff     <= 28'(cfg.max_y_ratio) * 28'(s_ff);
      p_x_ff     <= 28'(cfg.min_x_ratio) * 28'(s_ff);
      dxsq_ff    <= 32'(dx_ff) * 32'(dx_ff);
      dysq_ff    <= 32'(dy_ff) * 32'(dy_ff);
      hi_ff      <= 29'(cfg.max_dist_ratio) * 29'(s_ff);
      lo_ff      <= 29'(cfg.min_dist_ratio) * 29'(s_ff);
      x2_ff      <= x1_ff;
      y2_ff      <= y1_ff;
   end

   // Stage 3: ratio compares, squared distance and squared limits.
   logic        simple_ok3_ff;
   logic [32:0] sq_ff;
   logic [57:0] hi2_ff, lo2_ff;

   always_ff @(posedge clock) begin
      simple_ok3_ff <= ang_ok2_ff
                       && ({1'b0, ld2_ff, 8'd0} <= p_len_ff)
                       && ({3'd0, dy2_ff, 9'd0} <= p_y_ff)
                       && ({3'd0, dx2_ff, 9'd0} >= p_x_ff);
      sq_ff  <= {1'b0, dxsq_ff} + {1'b0, dysq_ff};
      hi2_ff <= 58'(hi_ff) * 58'(hi_ff);
      lo2_ff <= 58'(lo_ff) * 58'(lo_ff);
      x3_ff  <= x2_ff;
      y3_ff  <= y2_ff;
   end

   // Stage 4: distance window.
   logic [57:0] d2;
   logic        pass_ff;
   assign d2 = {7'd0, sq_ff, 18'd0};

   always_ff @(posedge clock) begin
      pass_ff <= simple_ok3_ff && (d2 <= hi2_ff) && (d2 >= lo2_ff);
      x4_ff   <= x3_ff;
      y4_ff   <= y3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign done   = v4_ff;
   assign pass   = pass_ff;
   assign mean_x = x4_ff;
   assign mean_y = y4_ff;

endmodule
`default_nettype wire

>>> rtl/lbpm_front.sv
// Front part: bar loading with running rank, sort order build and pair
// sequencing. Depends on lbpm_pkg, lbpm_if and lbpm_pair_test.
`default_nettype none
module lbpm_front
   import lbpm_pkg::*;
#(
   parameter int MAX_BARS   = MAX_BARS_DEF,
   parameter int MAX_ARMORS = MAX_ARMORS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   lbpm_req_if.sink     req,
   input  wire cfg_type cfg,
   input  wire logic    q_full,
   output q_push_type   q_push
);

   localparam int IDXW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
   localparam int CW   = $clog2(MAX_BARS + 1);
   localparam int AW   = $clog2(MAX_ARMORS + 1);

   typedef enum logic [7:0] {
      S_LOAD  = 8'b0000_0001,
      S_ORDER = 8'b0000_0010,
      S_PORD  = 8'b0000_0100,
      S_PBAR  = 8'b0000_1000,
      S_PTEST = 8'b0001_0000,
      S_PWAIT = 8'b0010_0000,
      S_PUSH  = 8'b0100_0000,
      S_END   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   v_ff, v_in, i_ff, i_in, j_ff, j_in;
   logic [AW-1:0]   armors_ff, armors_in;
   logic            dropped_ff, dropped_in;
   logic [15:0]     cx_ff   [MAX_BARS];
   logic [IDXW-1:0] rank_ff [MAX_BARS];
   logic [IDXW-1:0] rank_new;
   logic [15:0]     res_x_ff, res_y_ff;

   bar_type         bar_mem [MAX_BARS];
   logic [IDXW-1:0] ord_mem [MAX_BARS];
   logic [IDXW-1:0] ord_a_ff, ord_b_ff;
   bar_type         bar_a_ff, bar_b_ff;

   logic    accept, store_we, test_start, test_done, test_pass;
   logic [15:0] test_x, test_y;
   bar_type new_bar;

   assign req.ready = (state_ff == S_LOAD);
   assign accept    = req.valid && req.ready;
   assign store_we  = accept && (count_ff < CW'(MAX_BARS));
   assign new_bar   = '{cx: req.center_x, cy: req.center_y, len: req.bar_length,
                        ang: req.bar_angle};

   // Rank of the arriving bar: earlier bars with equal or smaller x stay ahead.
   always_comb begin
      rank_new = '0;
      for (int e = 0; e < MAX_BARS; e++) begin
         if ((CW'(e) < count_ff) && (cx_ff[e] <= req.center_x))
            rank_new = rank_new + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int e = 0; e < MAX_BARS; e++) begin
         if (store_we) begin
            if (CW'(e) == count_ff) begin
               cx_ff[e]   <= req.center_x;
               rank_ff[e] <= rank_new;
            end else if ((CW'(e) < count_ff) && (cx_ff[e] > req.center_x)) begin
               rank_ff[e] <= rank_ff[e] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_we)
         bar_mem[count_ff[IDXW-1:0]] <= new_bar;
      bar_a_ff <= bar_mem[ord_a_ff];
      bar_b_ff <= bar_mem[ord_b_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_ORDER)
         ord_mem[rank_ff[v_ff[IDXW-1:0]]] <= v_ff[IDXW-1:0];
      ord_a_ff <= ord_mem[i_ff[IDXW-1:0]];
      ord_b_ff <= ord_mem[j_ff[IDXW-1:0]];
   end

   assign test_start = (state_ff == S_PTEST);

   lbpm_pair_test u_test (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .start  (test_start),
      .bar_a  (bar_a_ff),
      .bar_b  (bar_b_ff),
      .done   (test_done),
      .pass   (test_pass),
      .mean_x (test_x),
      .mean_y (test_y)
   );

   always_ff @(posedge clock) begin
      if (test_done) begin
         res_x_ff <= test_x;
         res_y_ff <= test_y;
      end
   end

   // Next pair in i-then-j order.
   logic [CW:0] j_next, i_skip;
   logic        more_j, more_i;
   assign j_next = {1'b0, j_ff} + 1'b1;
   assign i_skip = {1'b0, i_ff} + 2'd2;
   assign more_j = j_next < {1'b0, count_ff};
   assign more_i = i_skip < {1'b0, count_ff};

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      v_in       = v_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      armors_in  = armors_ff;
      dropped_in = dropped_ff;
      q_push     = '0;
      case (state_ff)
         S_LOAD: begin
            if (store_we)
               count_in = count_ff + 1'b1;
            if (accept && req.last_bar) begin
               v_in     = '0;
               state_in = S_ORDER;
            end
         end
         S_ORDER: begin
            v_in = v_ff + 1'b1;
            if (v_ff == count_ff - 1'b1) begin
               i_in     = '0;
               j_in     = CW'(1);
               state_in = (count_ff < CW'(2)) ? S_END : S_PORD;
            end
         end
         S_PORD:  state_in = S_PBAR;
         S_PBAR:  state_in = S_PTEST;
         S_PTEST: state_in = S_PWAIT;
         S_PWAIT: begin
            if (test_done) begin
               if (test_pass && (armors_ff < AW'(MAX_ARMORS))) begin
                  state_in = S_PUSH;
               end else begin
                  if (test_pass)
                     dropped_in = 1'b1;
                  if (more_j) begin
                     j_in = j_next[CW-1:0]; state_in = S_PORD;
                  end else if (more_i) begin
                     i_in = i_ff + 1'b1; j_in = i_skip[CW-1:0]; state_in = S_PORD;
                  end else begin
                     state_in = S_END;
                  end
               end
            end
         end
         S_PUSH: begin
            if (!q_full) begin
               q_push.push              = 1'b1;
               q_push.entry.armor_x     = res_x_ff;
               q_push.entry.armor_y     = res_y_ff;
               q_push.entry.left_index  = 4'(i_ff);
               q_push.entry.right_index = 4'(j_ff);
               armors_in = armors_ff + 1'b1;
               if (more_j) begin
                  j_in = j_next[CW-1:0]; state_in = S_PORD;
               end else if (more_i) begin
                  i_in = i_ff + 1'b1; j_in = i_skip[CW-1:0]; state_in = S_PORD;
               end else begin
                  state_in = S_END;
               end
            end
         end
         S_END: begin
            if (!q_full) begin
               q_push.push          = 1'b1;
               q_push.entry.is_end  = 1'b1;
               q_push.entry.dropped = dropped_ff;
               count_in   = '0;
               armors_in  = '0;
               dropped_in = 1'b0;
               state_in   = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         count_ff   <= '0;
         v_ff       <= '0;
         i_ff       <= '0;
         j_ff       <= '0;
         armors_ff  <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         v_ff       <= v_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         armors_ff  <= armors_in;
         dropped_ff <= dropped_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_BARS))
      else $error("bar count beyond store depth");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      test_done |-> state_ff == S_PWAIT)
      else $error("pair test finished outside its wait state");
   a_armor_limit: assert property (@(posedge clock) disable iff (reset)
      q_push.push && !q_push.entry.is_end |-> armors_ff < AW'(MAX_ARMORS))
      else $error("armor pushed beyond limit");

endmodule
`default_nettype wire

>>> rtl/lbpm_back.sv
// Back part: result queue, held-back pending pair and output register that
// marks the last result of a frame. Depends on lbpm_pkg and lbpm_if.
`default_nettype none
module lbpm_back
   import lbpm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_push_type q_push,
   output logic            q_full,
   lbpm_rsp_if.source      rsp
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   q_entry_type     q_mem [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]   n_ff;
   q_entry_type     head, pend_ff;
   logic            pend_valid_ff, pend_valid_in;
   logic            out_valid_ff, out_valid_in, out_free, out_load, pop, pend_load;
   logic [15:0]     out_x_ff, out_y_ff;
   logic [3:0]      out_li_ff, out_ri_ff;
   logic            out_av_ff, out_ovf_ff, out_last_ff;

   assign head     = q_mem[rd_ptr_ff];
   assign q_full   = (n_ff == NW'(QUEUE_DEPTH));
   assign out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      pop           = 1'b0;
      out_load      = 1'b0;
      pend_load     = 1'b0;
      pend_valid_in = pend_valid_ff;
      if (n_ff != '0) begin
         if (!head.is_end) begin
            if (!pend_valid_ff) begin
               pop = 1'b1; pend_load = 1'b1; pend_valid_in = 1'b1;
            end else if (out_free) begin
               pop = 1'b1; pend_load = 1'b1; out_load = 1'b1;
            end
         end else if (out_free) begin
            pop = 1'b1; out_load = 1'b1; pend_valid_in = 1'b0;
         end
      end
      out_valid_in = out_load || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (q_push.push)
         q_mem[wr_ptr_ff] <= q_push.entry;
      if (pend_load)
         pend_ff <= head;
      if (out_load) begin
         if (pend_valid_ff) begin
            out_x_ff  <= pend_ff.armor_x;
            out_y_ff  <= pend_ff.armor_y;
            out_li_ff <= pend_ff.left_index;
            out_ri_ff <= pend_ff.right_index;
            out_av_ff <= 1'b1;
         end else begin
            out_x_ff  <= '0;
            out_y_ff  <= '0;
            out_li_ff <= '0;
            out_ri_ff <= '0;
            out_av_ff <= 1'b0;
         end
         out_last_ff <= head.is_end;
         out_ovf_ff  <= head.is_end && head.dropped && pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (q_push.push)
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         n_ff          <= n_ff + NW'(q_push.push) - NW'(pop);
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.armor_x     = out_x_ff;
   assign rsp.armor_y     = out_y_ff;
   assign rsp.left_index  = out_li_ff;
   assign rsp.right_index = out_ri_ff;
   assign rsp.armor_valid = out_av_ff;
   assign rsp.overflow    = out_ovf_ff;
   assign rsp.last_armor  = out_last_ff;

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push.push |-> !q_full)
      else $error("push into a full result queue");

endmodule
`default_nettype wire

>>> rtl/light_bar_pair_matcher_core.sv
// Top level of the light bar pair matcher: configuration registers and the
// front and back parts. Depends on lbpm_pkg, lbpm_if, lbpm_front, lbpm_back.
//
// Bars of one frame are taken one per cycle while the front is loading;
// bars beyond MAX_BARS are dropped, though their last_bar flag still ends
// the frame. After the bar that carries last_bar the input stays stalled
// while the frame is matched: the sorted order by center x is built from
// ranks that were kept up to date during loading, then each of the
// n(n-1)/2 pairs passes two store read stages, an issue state and the
// four-stage pair test; passing pairs, up to MAX_ARMORS, are pushed into
// the result queue and an end entry closes the frame, waiting on a full queue.
// The pair test is the bottleneck. Results drain through a four-entry queue
// and a held-back pending pair, so that the final result of a frame can
// carry last_armor and overflow; a frame with no matching pair gives one
// result with armor_valid low. The output register lets the next frame
// load while earlier results still wait for their transfer, and
// configuration should only be written while the block is idle.
`default_nettype none
module light_bar_pair_matcher_core
   import lbpm_pkg::*;
#(
   parameter int MAX_BARS   = MAX_BARS_DEF,
   parameter int MAX_ARMORS = MAX_ARMORS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   lbpm_req_if.sink                    req_ch,
   lbpm_rsp_if.source                  rsp_ch,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type    cfg_ff;
   q_push_type q_push;
   logic       q_full;

   // Configuration registers; each keeps the low bits of the written data.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_angle_diff   <= RST_MAX_ANGLE_DIFF;
         cfg_ff.max_length_ratio <= RST_MAX_LENGTH_RATIO;
         cfg_ff.max_y_ratio      <= RST_MAX_Y_RATIO;
         cfg_ff.min_x_ratio      <= RST_MIN_X_RATIO;
         cfg_ff.max_dist_ratio   <= RST_MAX_DIST_RATIO;
         cfg_ff.min_dist_ratio   <= RST_MIN_DIST_RATIO;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_ANGLE_DIFF:   cfg_ff.max_angle_diff   <= csr_write_data[10:0];
            CSR_MAX_LENGTH_RATIO: cfg_ff.max_length_ratio <= csr_write_data[8:0];
            CSR_MAX_Y_RATIO:      cfg_ff.max_y_ratio      <= csr_write_data[10:0];
            CSR_MIN_X_RATIO:      cfg_ff.min_x_ratio      <= csr_write_data[10:0];
            CSR_MAX_DIST_RATIO:   cfg_ff.max_dist_ratio   <= csr_write_data;
            CSR_MIN_DIST_RATIO:   cfg_ff.min_dist_ratio   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // The front loads bars and walks the pairs; it stalls only on a full queue.
   lbpm_front #(
      .MAX_BARS   (MAX_BARS),
      .MAX_ARMORS (MAX_ARMORS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .q_push (q_push)
   );

   // The back formats and delivers results at the pace of the consumer.
   lbpm_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .rsp    (rsp_ch)
   );

endmodule
`default_nettype wire
